// File: hdl/pctd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared types, character codes and helper functions of the percent decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int MAX_RES    = 3;
    localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
    localparam int RES_IDX_W  = $clog2(MAX_RES);

    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_AMP       = 8'h26;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_TWO       = 8'h32;
    localparam logic [7:0] CH_FIVE      = 8'h35;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_D   = 8'h44;

    typedef enum logic [2:0]
    {
        PH_IDLE = 3'd0,
        PH_BSL  = 3'd1,
        PH_PCT  = 3'd2,
        PH_HEX  = 3'd3
    } phase_t;

    typedef struct packed
    {
        logic [RES_CNT_W-1:0]      count;
        logic [MAX_RES-1:0][7:0]   data;
        logic [MAX_RES-1:0]        last;
    } result_set_t;

    function automatic logic is_hex(input logic [7:0] b);
        return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b inside {[8'h30:8'h39]})
        begin
            v = b - 8'h30;
        end
        else if (b inside {[8'h41:8'h46]})
        begin
            v = b - 8'h37;
        end
        else if (b inside {[8'h61:8'h66]})
        begin
            v = b - 8'h57;
        end
        return v[3:0];
    endfunction

    function automatic result_set_t push(input result_set_t rs, input logic [7:0] b);
        result_set_t r;
        r = rs;
        if (r.count < RES_CNT_W'(MAX_RES))
        begin
            r.data[r.count[RES_IDX_W-1:0]] = b;
            r.count = r.count + 1'b1;
        end
        return r;
    endfunction

    function automatic result_set_t push_decoded(input result_set_t rs, input logic [7:0] v);
        result_set_t r;
        logic [7:0]  c;
        r = rs;
        c = (v == CH_DQUOTE) ? CH_SQUOTE : v;
        if (c == CH_EQUAL || c == CH_AMP)
        begin
            r = push(r, CH_BACKSLASH);
        end
        r = push(r, c);
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/pctd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_decode
// Escape state registers and the single-pass decode of one request.
// ----------------------------------------------------------------------------
module pctd_decode
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire logic [7:0]            byte_in,
    input  wire logic                  last_in,
    output pctd_pkg::result_set_t      results
);

    pctd_pkg::phase_t phase_reg;
    pctd_pkg::phase_t phase_next;
    logic [7:0]       held_digit_reg;
    logic [7:0]       held_digit_next;
    logic             dropped_25_reg;
    logic             dropped_25_next;

    always_comb
    begin
        pctd_pkg::result_set_t rs;
        pctd_pkg::phase_t      ph;
        logic [7:0]            hd;
        logic                  d25;
        logic                  fresh;

        rs    = '0;
        ph    = pctd_pkg::PH_IDLE;
        hd    = held_digit_reg;
        d25   = dropped_25_reg;
        fresh = 1'b0;

        case (phase_reg)
            pctd_pkg::PH_BSL:
            begin
                if (byte_in == pctd_pkg::CH_COMMA)
                begin
                    rs = pctd_pkg::push(rs, pctd_pkg::CH_COMMA);
                end
                else
                begin
                    rs    = pctd_pkg::push(rs, pctd_pkg::CH_BACKSLASH);
                    fresh = 1'b1;
                end
            end
            pctd_pkg::PH_PCT:
            begin
                if (pctd_pkg::is_hex(byte_in))
                begin
                    hd = byte_in;
                    ph = pctd_pkg::PH_HEX;
                end
                else
                begin
                    rs = pctd_pkg::push(rs, pctd_pkg::CH_PERCENT);
                    if (pctd_pkg::is_alnum(byte_in))
                    begin
                        rs = pctd_pkg::push(rs, byte_in);
                    end
                    else
                    begin
                        fresh = 1'b1;
                    end
                end
            end
            pctd_pkg::PH_HEX:
            begin
                if (held_digit_reg == pctd_pkg::CH_TWO && !dropped_25_reg
                    && byte_in == pctd_pkg::CH_FIVE)
                begin
                    d25 = 1'b1;
                    ph  = pctd_pkg::PH_PCT;
                end
                else if (held_digit_reg == pctd_pkg::CH_ZERO
                         && (byte_in == pctd_pkg::CH_UPPER_A
                             || byte_in == pctd_pkg::CH_UPPER_D))
                begin
                    rs = pctd_pkg::push(rs, pctd_pkg::CH_PERCENT);
                    rs = pctd_pkg::push(rs, pctd_pkg::CH_ZERO);
                    rs = pctd_pkg::push(rs, byte_in);
                end
                else if (pctd_pkg::is_hex(byte_in))
                begin
                    rs = pctd_pkg::push_decoded(rs, {pctd_pkg::hex_val(held_digit_reg),
                                                     pctd_pkg::hex_val(byte_in)});
                end
                else
                begin
                    rs = pctd_pkg::push_decoded(rs, {4'h0,
                                                     pctd_pkg::hex_val(held_digit_reg)});
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        if (fresh)
        begin
            if (byte_in == pctd_pkg::CH_PERCENT)
            begin
                ph  = pctd_pkg::PH_PCT;
                d25 = 1'b0;
            end
            else if (byte_in == pctd_pkg::CH_BACKSLASH)
            begin
                ph = pctd_pkg::PH_BSL;
            end
            else
            begin
                rs = pctd_pkg::push(rs, byte_in);
            end
        end

        if (last_in)
        begin
            case (ph)
                pctd_pkg::PH_BSL:
                begin
                    rs = pctd_pkg::push(rs, pctd_pkg::CH_BACKSLASH);
                end
                pctd_pkg::PH_PCT:
                begin
                    rs = pctd_pkg::push(rs, pctd_pkg::CH_PERCENT);
                end
                pctd_pkg::PH_HEX:
                begin
                    rs = pctd_pkg::push_decoded(rs, {4'h0, pctd_pkg::hex_val(hd)});
                end
                default:
                begin
                end
            endcase
            if (rs.count != '0)
            begin
                rs.last[pctd_pkg::RES_IDX_W'(rs.count - 1'b1)] = 1'b1;
            end
            ph  = pctd_pkg::PH_IDLE;
            hd  = 8'h00;
            d25 = 1'b0;
        end

        results         = rs;
        phase_next      = ph;
        held_digit_next = hd;
        dropped_25_next = d25;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= pctd_pkg::PH_IDLE;
            held_digit_reg <= 8'h00;
            dropped_25_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            held_digit_reg <= held_digit_next;
            dropped_25_reg <= dropped_25_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/pctd_result_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_result_queue
// Result buffer: takes up to three results at once, drains one unless stalled.
// ----------------------------------------------------------------------------
module pctd_result_queue
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire pctd_pkg::result_set_t wr_set,
    output logic                       room,
    output logic                       valid,
    input  wire logic                  stall,
    output logic [7:0]                 out_byte,
    output logic                       out_last
);

    logic [pctd_pkg::QDEPTH-1:0][8:0] mem_reg;
    logic [pctd_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [pctd_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [pctd_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [pctd_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [pctd_pkg::QCNT_W-1:0]      count_reg;
    logic [pctd_pkg::QCNT_W-1:0]      count_next;
    logic [pctd_pkg::QCNT_W-1:0]      add;
    logic                             drain;

    assign valid    = (count_reg != '0);
    assign drain    = valid && !stall;
    assign room     = (count_reg <= pctd_pkg::QCNT_W'(pctd_pkg::QDEPTH - pctd_pkg::MAX_RES));
    assign out_byte = mem_reg[rd_ptr_reg][8:1];
    assign out_last = mem_reg[rd_ptr_reg][0];
    assign add      = wr_en ? pctd_pkg::QCNT_W'(wr_set.count) : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + pctd_pkg::QPTR_W'(add);
        rd_ptr_next = drain ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + add - pctd_pkg::QCNT_W'(drain);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int i = 0; i < pctd_pkg::MAX_RES; i++)
            begin
                if (pctd_pkg::RES_CNT_W'(i) < wr_set.count)
                begin
                    mem_reg[wr_ptr_reg + pctd_pkg::QPTR_W'(i)] <=
                        {wr_set.data[i], wr_set.last[i]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/percent_escape_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// percent_escape_decoder_core
// Streaming percent-escape decoder, one raw byte per request.
// ----------------------------------------------------------------------------
// An accepted request is held in the input stage until the buffer has room.
// Throughput: one request per cycle while the result buffer has room for three
// results; the output port drains one result per cycle when out_stall is low,
// so the output side sets the sustained rate for multi-result requests.
// Reset: asynchronous, clears escape state, input stage and result buffer.
module percent_escape_decoder_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic                  hold_valid_reg;
    logic                  hold_valid_next;
    logic [7:0]            byte_reg;
    logic                  last_reg;
    logic                  room;
    logic                  take;
    logic                  load;
    pctd_pkg::result_set_t results;

    assign take            = hold_valid_reg && room;
    assign in_stall        = hold_valid_reg && !room;
    assign load            = in_valid && !in_stall;
    assign hold_valid_next = load ? 1'b1 : (take ? 1'b0 : hold_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    pctd_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (take),
        .byte_in (byte_reg),
        .last_in (last_reg),
        .results (results)
    );

    pctd_result_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (take),
        .wr_set   (results),
        .room     (room),
        .valid    (out_valid),
        .stall    (out_stall),
        .out_byte (out_byte),
        .out_last (out_last)
    );

endmodule
`default_nettype wire
